### design/pbd_pkg.sv
// Package for the optical pulse beat detector.
// Holds shared constants, the register index codes and the FIR tap coefficients.
// No dependencies.
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int DELAY_DEPTH_DEF = 32;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int COEF_W   = 14;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int TAP_W    = 4;
    localparam int SPAN     = 22;

    localparam logic [TAP_W-1:0] CENTER_TAP = 4'd11;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SWING = 2'd0,
        CFG_MAX_SWING = 2'd1,
        CFG_DC_SHIFT  = 2'd2
    } t_cfg_index;

    localparam logic [15:0] MIN_SWING_RST = 16'd20;
    localparam logic [15:0] MAX_SWING_RST = 16'd1000;
    localparam logic [3:0]  DC_SHIFT_RST  = 4'd4;

    typedef struct packed {
        logic             clear;
        logic             issue;
        logic [TAP_W-1:0] tap;
    } t_mac_ctl;

    function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            4'd0:    c = 14'sd172;
            4'd1:    c = 14'sd321;
            4'd2:    c = 14'sd579;
            4'd3:    c = 14'sd927;
            4'd4:    c = 14'sd1360;
            4'd5:    c = 14'sd1858;
            4'd6:    c = 14'sd2390;
            4'd7:    c = 14'sd2916;
            4'd8:    c = 14'sd3391;
            4'd9:    c = 14'sd3768;
            4'd10:   c = 14'sd4012;
            4'd11:   c = 14'sd4096;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

endpackage

### design/pbd_line_mem.sv
// Circular delay line of AC samples: one write port, two registered read ports.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses pbd_pkg.
`timescale 1ns / 1ps

module pbd_line_mem #(
    parameter int DEPTH = pbd_pkg::DELAY_DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [PTR_W-1:0]              i_waddr,
    input  logic [pbd_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [PTR_W-1:0]              i_raddr_a,
    input  logic [PTR_W-1:0]              i_raddr_b,
    output logic [pbd_pkg::SAMPLE_W-1:0]  o_rdata_a,
    output logic [pbd_pkg::SAMPLE_W-1:0]  o_rdata_b
);
    import pbd_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;
    logic [SAMPLE_W-1:0] r_rd_a;
    logic [SAMPLE_W-1:0] r_rd_b;
    logic                r_vld_a;
    logic                r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_vld_a <= r_vld[i_raddr_a];
                r_vld_b <= r_vld[i_raddr_b];
            end
        end
    end

    assign o_rdata_a = r_vld_a ? r_rd_a : '0;
    assign o_rdata_b = r_vld_b ? r_rd_b : '0;

endmodule

### design/pbd_mac.sv
// Shared multiply-accumulate unit for the symmetric low-pass FIR.
// Pair add and coefficient multiply, registered product, then accumulate. Uses pbd_pkg.
`timescale 1ns / 1ps

module pbd_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pbd_pkg::t_mac_ctl                    i_ctl,
    input  logic [pbd_pkg::SAMPLE_W-1:0]         i_tap_a,
    input  logic [pbd_pkg::SAMPLE_W-1:0]         i_tap_b,
    output logic                                 o_busy,
    output logic signed [pbd_pkg::SAMPLE_W-1:0]  o_ac
);
    import pbd_pkg::*;

    logic                        r_v1;
    logic                        r_v2;
    logic [TAP_W-1:0]            r_tap1;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic [SAMPLE_W-1:0]         w_pair;
    logic signed [PROD_W-1:0]    w_prod;

    always_comb begin
        w_pair = i_tap_a + ((r_tap1 == CENTER_TAP) ? '0 : i_tap_b);
        w_prod = $signed(w_pair) * tap_coef(r_tap1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1   <= i_ctl.issue;
            r_tap1 <= i_ctl.tap;
            r_v2   <= r_v1;
            if (r_v1) begin
                r_prod <= w_prod;
            end
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_ac   = r_acc[ACC_W-2:ACC_W-1-SAMPLE_W];

endmodule

### design/ppg_beat_detector.sv
// Top level of the optical pulse beat detector: sequencer, DC tracker and beat logic.
// Instantiates pbd_line_mem and pbd_mac; uses pbd_pkg.
`timescale 1ns / 1ps

// One sample is accepted whenever o_ready is high and gives exactly one result.
// Between one transfer and the earliest next transfer an item passes through the transfer
// cycle, the DC update (difference, then accumulate), the store of the AC sample in the delay
// line, the tap reads through the single multiplier (one per coefficient, the center tap
// last) and the drain of the multiply-accumulate pipeline with the beat decision. The result
// is held in an output register, so the next sample is taken while a result waits; if a
// result is still unclaimed when the next one is ready, the block holds until it is taken.
// Configuration writes are always accepted and take effect at once; make them only while
// no sample is in flight.
module ppg_beat_detector #(
    parameter int DELAY_DEPTH = pbd_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [15:0]                          i_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_beat,
    output logic signed [15:0]                   o_ac_value,
    output logic [15:0]                          o_dc_estimate,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pbd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);
    import pbd_pkg::*;

    localparam int PTR_W    = $clog2(DELAY_DEPTH);
    localparam int DEPTH_M1 = DELAY_DEPTH - 1;
    localparam logic [PTR_W:0]   DEPTH_X  = DELAY_DEPTH[PTR_W:0];
    localparam logic [PTR_W:0]   SPAN_X   = SPAN[PTR_W:0];
    localparam logic [PTR_W-1:0] LAST_PTR = DEPTH_M1[PTR_W-1:0];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DC_DIFF,
        ST_DC_ACC,
        ST_WRITE,
        ST_TAPS,
        ST_DRAIN
    } t_state;

    t_state                r_state;
    logic [15:0]           r_min_swing;
    logic [15:0]           r_max_swing;
    logic [3:0]            r_dc_shift;
    logic [15:0]           r_x;
    logic signed [32:0]    r_diff;
    logic [ACC_W-1:0]      r_acc;
    logic [PTR_W-1:0]      r_wp;
    logic [TAP_W-1:0]      r_k;
    logic signed [15:0]    r_last;
    logic signed [15:0]    r_peak;
    logic signed [15:0]    r_trough;
    logic                  r_pos;
    logic                  r_neg;
    logic                  r_o_valid;
    logic                  r_o_beat;
    logic signed [15:0]    r_o_ac;
    logic [15:0]           r_o_dc;

    logic signed [32:0]    w_shifted;
    logic [ACC_W-1:0]      n_acc;
    logic [PTR_W:0]        w_back_a;
    logic [PTR_W:0]        w_back_b;
    logic [PTR_W:0]        w_sum_a;
    logic [PTR_W:0]        w_sum_b;
    logic [PTR_W-1:0]      w_addr_a;
    logic [PTR_W-1:0]      w_addr_b;
    logic [15:0]           w_ac_in;
    logic [15:0]           w_tap_a;
    logic [15:0]           w_tap_b;
    logic                  w_busy;
    logic signed [15:0]    w_cur;
    t_mac_ctl              w_ctl;
    logic                  w_rising;
    logic                  w_falling;
    logic signed [16:0]    w_swing;
    logic                  w_beat;
    logic                  n_pos;
    logic                  n_neg;
    logic signed [15:0]    n_peak;
    logic signed [15:0]    n_trough;
    logic                  w_done;

    // DC tracker: acc += ((x << 15) - acc) >>> shift
    always_comb begin
        w_shifted = r_diff >>> r_dc_shift;
        n_acc     = r_acc + w_shifted[ACC_W-1:0];
        w_ac_in   = r_x - r_acc[30:15];
    end

    // Tap addresses: wp - k and wp - (22 - k), modulo depth
    always_comb begin
        w_back_a = {{(PTR_W-TAP_W+1){1'b0}}, r_k};
        w_back_b = SPAN_X - w_back_a;
        w_sum_a  = {1'b0, r_wp} + DEPTH_X - w_back_a;
        w_sum_b  = {1'b0, r_wp} + DEPTH_X - w_back_b;
        w_addr_a = (w_sum_a >= DEPTH_X) ? w_sum_a[PTR_W-1:0] - LAST_PTR - 1'b1
                                        : w_sum_a[PTR_W-1:0];
        w_addr_b = (w_sum_b >= DEPTH_X) ? w_sum_b[PTR_W-1:0] - LAST_PTR - 1'b1
                                        : w_sum_b[PTR_W-1:0];
    end

    always_comb begin
        w_ctl.clear = (r_state == ST_WRITE);
        w_ctl.issue = (r_state == ST_TAPS);
        w_ctl.tap   = r_k;
    end

    pbd_line_mem #(
        .DEPTH (DELAY_DEPTH),
        .PTR_W (PTR_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (r_state == ST_WRITE),
        .i_waddr   (r_wp),
        .i_wdata   (w_ac_in),
        .i_re      (r_state == ST_TAPS),
        .i_raddr_a (w_addr_a),
        .i_raddr_b (w_addr_b),
        .o_rdata_a (w_tap_a),
        .o_rdata_b (w_tap_b)
    );

    pbd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_tap_a (w_tap_a),
        .i_tap_b (w_tap_b),
        .o_busy  (w_busy),
        .o_ac    (w_cur)
    );

    // Zero-crossing tracking and beat decision
    always_comb begin
        w_rising  = (r_last < 0) && (w_cur >= 0);
        w_falling = (r_last > 0) && (w_cur <= 0);
        w_swing   = {r_peak[15], r_peak} - {r_trough[15], r_trough};
        w_beat    = w_rising
                    && ($signed({w_swing[16], w_swing}) > $signed({2'b00, r_min_swing}))
                    && ($signed({w_swing[16], w_swing}) < $signed({2'b00, r_max_swing}));
        n_pos     = w_rising ? 1'b1 : (w_falling ? 1'b0 : r_pos);
        n_neg     = w_falling ? 1'b1 : (w_rising ? 1'b0 : r_neg);
        n_peak    = w_rising ? '0 : r_peak;
        n_trough  = w_falling ? '0 : r_trough;
        if (n_pos && (w_cur > r_last)) begin
            n_peak = w_cur;
        end
        if (n_neg && (w_cur < r_last)) begin
            n_trough = w_cur;
        end
        w_done    = (r_state == ST_DRAIN) && !w_busy && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_swing <= MIN_SWING_RST;
            r_max_swing <= MAX_SWING_RST;
            r_dc_shift  <= DC_SHIFT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_SWING: r_min_swing <= i_cfg_data;
                CFG_MAX_SWING: r_max_swing <= i_cfg_data;
                CFG_DC_SHIFT:  r_dc_shift  <= i_cfg_data[3:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_wp      <= '0;
            r_k       <= '0;
            r_last    <= '0;
            r_peak    <= '0;
            r_trough  <= '0;
            r_pos     <= 1'b0;
            r_neg     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !w_done) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_sample;
                        r_state <= ST_DC_DIFF;
                    end
                end
                ST_DC_DIFF: begin
                    r_diff  <= $signed({2'b00, r_x, 15'b0}) - $signed({r_acc[ACC_W-1], r_acc});
                    r_state <= ST_DC_ACC;
                end
                ST_DC_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_k     <= '0;
                    r_state <= ST_TAPS;
                end
                ST_TAPS: begin
                    if (r_k == CENTER_TAP) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_last    <= w_cur;
                        r_peak    <= n_peak;
                        r_trough  <= n_trough;
                        r_pos     <= n_pos;
                        r_neg     <= n_neg;
                        r_wp      <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
                        r_o_valid <= 1'b1;
                        r_o_beat  <= w_beat;
                        r_o_ac    <= w_cur;
                        r_o_dc    <= r_acc[30:15];
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_beat        = r_o_beat;
    assign o_ac_value    = r_o_ac;
    assign o_dc_estimate = r_o_dc;
    assign o_cfg_ready   = 1'b1;

endmodule

### tb/tb_ppg_beat_detector.sv
// Self-checking testbench for ppg_beat_detector: DC tracker, FIR low-pass and beat flag.
// Drives random pulse waveforms and noise under several register settings, with random stalls.
// Depends on pbd_pkg and the ppg_beat_detector RTL.
`timescale 1ns / 1ps

module tb_ppg_beat_detector;

    import pbd_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTED = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic               beat;
        logic signed [15:0] ac_value;
        logic [15:0]        dc_estimate;
    } t_pulse_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [15:0]          i_sample = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_beat;
    logic signed [15:0]   o_ac_value;
    logic [15:0]          o_dc_estimate;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data = '0;

    // predictor state
    logic [31:0]        dc_acc_m;
    logic signed [15:0] line_m [32];
    logic [4:0]         wp_m;
    logic signed [15:0] last_ac_m;
    logic signed [15:0] peak_m;
    logic signed [15:0] trough_m;
    logic               pos_half_m;
    logic               neg_half_m;
    logic [15:0]        min_swing_m;
    logic [15:0]        max_swing_m;
    logic [3:0]         dc_shift_m;
    int                 fir_coef [12] = '{172, 321, 579, 927, 1360, 1858,
                                          2390, 2916, 3391, 3768, 4012, 4096};

    logic [15:0] sample_q [$];
    t_pulse_out  pulse_expect [$];
    t_pulse_out  exp_head;
    int          n_sent = 0;
    int          n_taken = 0;
    int          n_seen = 0;
    int          n_err = 0;
    int          n_cycles = 0;
    int          tx_idle_pct = 25;
    int          rx_idle_pct = 25;
    logic        rx_hold = 1'b0;

    ppg_beat_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_beat        (o_beat),
        .o_ac_value    (o_ac_value),
        .o_dc_estimate (o_dc_estimate),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic void pulse_clear();
        dc_acc_m = '0;
        for (int i = 0; i < 32; i++) line_m[i] = '0;
        wp_m = '0;
        last_ac_m = '0;
        peak_m = '0;
        trough_m = '0;
        pos_half_m = 1'b0;
        neg_half_m = 1'b0;
        min_swing_m = MIN_SWING_RST;
        max_swing_m = MAX_SWING_RST;
        dc_shift_m = DC_SHIFT_RST;
    endfunction

    function automatic logic signed [15:0] line_at(input logic [4:0] back);
        logic [4:0] idx;
        idx = wp_m - back;
        return line_m[idx];
    endfunction

    function automatic t_pulse_out pulse_step(input logic [15:0] x);
        longint             acc;
        longint             diff;
        longint             z;
        logic [15:0]        dc;
        logic signed [15:0] pair;
        logic signed [15:0] cur;
        logic signed [15:0] prev;
        int                 swing;
        t_pulse_out         r;
        acc = longint'($signed(dc_acc_m));
        diff = (longint'({48'd0, x}) <<< 15) - acc;
        acc = acc + (diff >>> dc_shift_m);
        dc_acc_m = acc[31:0];
        dc = dc_acc_m[30:15];
        line_m[wp_m] = x - dc;
        z = fir_coef[11] * longint'(line_at(5'd11));
        for (int i = 0; i < 11; i++) begin
            pair = line_at(5'(i)) + line_at(5'(22 - i));
            z = z + fir_coef[i] * longint'(pair);
        end
        wp_m = wp_m + 5'd1;
        z = z >>> 15;
        cur = z[15:0];
        prev = last_ac_m;
        last_ac_m = cur;
        r.beat = 1'b0;
        if (prev < 0 && cur >= 0) begin
            swing = int'(peak_m) - int'(trough_m);
            pos_half_m = 1'b1;
            neg_half_m = 1'b0;
            peak_m = '0;
            if (swing > int'({16'd0, min_swing_m}) && swing < int'({16'd0, max_swing_m}))
                r.beat = 1'b1;
        end
        if (prev > 0 && cur <= 0) begin
            pos_half_m = 1'b0;
            neg_half_m = 1'b1;
            trough_m = '0;
        end
        if (pos_half_m && cur > prev) peak_m = cur;
        if (neg_half_m && cur < prev) trough_m = cur;
        r.ac_value = cur;
        r.dc_estimate = dc;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        if (n_err < MAX_PRINTED)
            $display("result %0d: %s got %0d expected %0d", n_seen, what, got, want);
        n_err++;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pulse_expect.push_back(pulse_step(i_sample));
                n_taken++;
            end
            if (!i_valid || o_ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_valid <= 1'b1;
                    i_sample <= sample_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pulse_expect.size() == 0) begin
                    note_mismatch("unexpected result, ac_value", int'(o_ac_value), 0);
                end else begin
                    exp_head = pulse_expect.pop_front();
                    if (o_beat !== exp_head.beat)
                        note_mismatch("beat", int'(o_beat), int'(exp_head.beat));
                    if (o_ac_value !== exp_head.ac_value)
                        note_mismatch("ac_value", int'(o_ac_value), int'(exp_head.ac_value));
                    if (o_dc_estimate !== exp_head.dc_estimate)
                        note_mismatch("dc_estimate", int'(o_dc_estimate),
                                      int'(exp_head.dc_estimate));
                end
                n_seen++;
            end
            i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // hold off the receiver so the block backs up
    initial begin
        wait (n_taken >= 120);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void push_sample(input int v);
        sample_q.push_back(v[15:0]);
        n_sent++;
    endfunction

    function automatic void add_wave(input int n, input int base, input int amp,
                                     input int period, input int jit);
        int ph;
        int ramp;
        int v;
        for (int k = 0; k < n; k++) begin
            ph = k % period;
            ramp = (ph < period / 2) ? ph : period - ph;
            v = base - amp + (4 * amp * ramp) / period
                + int'($urandom_range(2 * jit)) - jit;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            push_sample(v);
        end
    endfunction

    function automatic void add_phase(input int n);
        int left;
        int kind;
        int len;
        int amp;
        left = n;
        while (left > 0) begin
            kind = $urandom_range(9);
            len = (kind < 8) ? $urandom_range(120, 30) : $urandom_range(15, 3);
            if (len > left) len = left;
            if (kind < 8) begin
                amp = (kind == 7) ? $urandom_range(20000, 2000) : $urandom_range(700, 4);
                add_wave(len, $urandom_range(60000, 5000), amp, $urandom_range(40, 6),
                         $urandom_range(amp / 8));
            end else begin
                for (int k = 0; k < len; k++) push_sample($urandom_range(65535));
            end
            left -= len;
        end
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MIN_SWING: min_swing_m = data;
            CFG_MAX_SWING: max_swing_m = data;
            CFG_DC_SHIFT:  dc_shift_m = data[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (n_seen != n_sent) @(posedge i_clk);
    endtask

    initial begin
        pulse_clear();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and sign boundaries, then a clean pulse train
        push_sample(0);
        push_sample(65535);
        push_sample(0);
        push_sample(65535);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(1);
        push_sample(16'hFFFE);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        add_wave(14, 30000, 300, 8, 0);
        add_phase(400);
        wait_idle();

        // widest beat window, DC shift of one, no idling
        cfg_write(CFG_MIN_SWING, 16'h0000);
        cfg_write(CFG_MAX_SWING, 16'hFFFF);
        cfg_write(CFG_DC_SHIFT, 16'hFFF1);
        cfg_write(CFG_IDX_UNUSED, 16'($urandom_range(65535)));
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        add_phase(250);
        wait_idle();
        tx_idle_pct <= 25;
        rx_idle_pct <= 25;

        // empty beat window, slowest tracking
        cfg_write(CFG_MIN_SWING, 16'hFFFF);
        cfg_write(CFG_MAX_SWING, 16'h0000);
        cfg_write(CFG_DC_SHIFT, 16'h000F);
        add_phase(150);
        wait_idle();

        // zero shift: DC jumps straight to the sample
        cfg_write(CFG_MIN_SWING, MIN_SWING_RST);
        cfg_write(CFG_MAX_SWING, MAX_SWING_RST);
        cfg_write(CFG_DC_SHIFT, 16'hABC0);
        add_phase(150);
        wait_idle();

        repeat (6) begin
            cfg_write(CFG_MIN_SWING, 16'($urandom_range(150)));
            cfg_write(CFG_MAX_SWING, 16'($urandom_range(4000, 150)));
            cfg_write(CFG_DC_SHIFT, {12'($urandom_range(4095)), 4'($urandom_range(15, 1))});
            if ($urandom_range(1) == 1)
                cfg_write(CFG_IDX_UNUSED, 16'($urandom_range(65535)));
            add_phase(150);
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_err == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
